// ----- rtl/json_stream_tokenizer_top_macros.svh -----
// Assertion macros for the JSON tokenizer
`ifndef JSON_STREAM_TOKENIZER_TOP_MACROS_SVH
`define JSON_STREAM_TOKENIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define JST_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define JST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define JST_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define JST_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/jst_pkg.sv -----
// ----------------------------------------------------------------------------
// jst_pkg
// Shared token codes, status codes and queue entry type for the tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;
  localparam logic [3:0] TK_BYTE    = 4'd0;
  localparam logic [3:0] TK_STR_B   = 4'd1;
  localparam logic [3:0] TK_STR_E   = 4'd2;
  localparam logic [3:0] TK_ARR_B   = 4'd3;
  localparam logic [3:0] TK_ARR_E   = 4'd4;
  localparam logic [3:0] TK_OBJ_B   = 4'd5;
  localparam logic [3:0] TK_OBJ_E   = 4'd6;
  localparam logic [3:0] TK_COMMA   = 4'd7;
  localparam logic [3:0] TK_COLON   = 4'd8;
  localparam logic [3:0] TK_FALSE   = 4'd9;
  localparam logic [3:0] TK_NULL    = 4'd10;
  localparam logic [3:0] TK_TRUE    = 4'd11;
  localparam logic [3:0] TK_EXP     = 4'd12;
  localparam logic [3:0] TK_FINISH  = 4'd13;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SYNTAX   = 3'd1;
  localparam logic [2:0] ST_ENCODING = 3'd2;
  localparam logic [2:0] ST_EARLY    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // one classified item: up to four tokens
  typedef struct packed {
    logic [2:0]      cnt;      // 1..4
    logic [3:0][3:0] kind;
    logic [3:0][7:0] byte_v;
    logic [2:0]      status;   // applies to finish tokens
  } tok_grp_t;
endpackage

// ----- rtl/json_stream_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// json_stream_tokenizer_top
// Streaming JSON validator and tokenizer, one code point per item.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_stall  | code_point, at_end, bad_encoding
// output  | out       | out_valid/out_stall| token_kind, byte_value, status, last
//
// An item passes the grammar stage; its 0..4 tokens leave the two-entry queue
// at one per cycle unless the output stalls, so with no stall the rate is one item
// per cycle when each makes at most one token and otherwise set by the output serializer.
// Reset clears phase, level and queue; the stack holds no reset.
// Input stalls only while the queue is full.
module json_stream_tokenizer_top #(
  parameter int NEST_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [20:0] code_point_i,
  input  logic        at_end_i,
  input  logic        bad_encoding_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  byte_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  logic              grp_valid, grp_full;
  jst_pkg::tok_grp_t grp;

  jst_front #(.NEST_DEPTH(NEST_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .code_point_i, .at_end_i,
    .bad_encoding_i, .grp_valid_o(grp_valid), .grp_full_i(grp_full), .grp_o(grp)
  );

  jst_back u_back (
    .clk_i, .rst_ni, .grp_valid_i(grp_valid), .grp_full_o(grp_full), .grp_i(grp),
    .out_valid_o, .out_stall_i, .token_kind_o, .byte_value_o, .status_o, .last_o
  );
endmodule

// ----- rtl/jst_front.sv -----
// ----------------------------------------------------------------------------
// jst_front
// Grammar state machine: accepts one code point per cycle unless the queue is full, emits a token group.
// ----------------------------------------------------------------------------
`include "json_stream_tokenizer_top_macros.svh"
module jst_front #(
  parameter int NEST_DEPTH = 64,
  parameter int LW = $clog2(NEST_DEPTH + 1),
  parameter int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [20:0]       code_point_i,
  input  logic              at_end_i,
  input  logic              bad_encoding_i,
  output logic              grp_valid_o,
  input  logic              grp_full_i,
  output jst_pkg::tok_grp_t grp_o
);
  localparam logic [4:0] PH_VALUE = 5'd0, PH_ARR_FIRST = 5'd1, PH_OBJ_FIRST = 5'd2,
    PH_OBJ_KEY = 5'd3, PH_COLON = 5'd4, PH_AFTER = 5'd5, PH_STR = 5'd6,
    PH_STR_ESC = 5'd7, PH_STR_HEX = 5'd8, PH_KEY = 5'd9, PH_KEY_ESC = 5'd10,
    PH_KEY_HEX = 5'd11, PH_FALSE = 5'd12, PH_NULL = 5'd13, PH_TRUE = 5'd14,
    PH_MINUS = 5'd15, PH_ZERO = 5'd16, PH_INT = 5'd17, PH_DOT = 5'd18,
    PH_FRAC = 5'd19, PH_EXP = 5'd20, PH_EXP_SIGN = 5'd21, PH_EXP_DIG = 5'd22;

  logic [4:0]  phase_q, phase_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [2:0]  sub_q, sub_d;
  logic        fin_q, fin_d;
  logic        top_q, top_d;    // kind of innermost open container (1 = object)
  logic        below_q;         // kind of the container under the innermost one
  logic        kinds_q [NEST_DEPTH];
  logic [LW-1:0] rd_lvl;
  logic        push, pop, push_kind;
  logic        acc;
  jst_pkg::tok_grp_t g;
  logic [20:0] c;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = grp_full_i;
  assign c          = code_point_i;
  assign rd_lvl     = acc ? lvl_d : lvl_q;

  function automatic logic is_ws(input logic [20:0] v);
    return v == 21'h20 || v == 21'h09 || v == 21'h0A || v == 21'h0D;
  endfunction
  function automatic logic is_dig(input logic [20:0] v);
    return v >= 21'h30 && v <= 21'h39;
  endfunction
  function automatic logic is_hex(input logic [20:0] v);
    return is_dig(v) || (v >= 21'h61 && v <= 21'h66) || (v >= 21'h41 && v <= 21'h46);
  endfunction
  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [1:0] i);
    logic [7:0] r;
    r = 8'h00;
    case ({w, i})
      4'b0000: r = 8'h61; 4'b0001: r = 8'h6C; 4'b0010: r = 8'h73; 4'b0011: r = 8'h65;
      4'b0100: r = 8'h75; 4'b0101: r = 8'h6C; 4'b0110: r = 8'h6C;
      4'b1000: r = 8'h72; 4'b1001: r = 8'h75; 4'b1010: r = 8'h65;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // grammar step
  always_comb begin
    logic       emit;
    logic       cls;
    logic       aft;
    logic       opn;
    logic       opn_obj;
    logic [1:0] w;
    logic [2:0] ni;
    logic       str_key;
    phase_d = phase_q; lvl_d = lvl_q; sub_d = sub_q; fin_d = fin_q; top_d = top_q;
    push = 1'b0; pop = 1'b0; push_kind = 1'b0;
    g = '0; emit = 1'b0; cls = 1'b0; aft = 1'b0; opn = 1'b0; opn_obj = 1'b0;
    w = 2'd0; ni = 3'd0; str_key = 1'b0;
    g.cnt = 3'd1;
    if (bad_encoding_i || (!at_end_i && c >= 21'h110000)) begin
      g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_ENCODING; emit = 1'b1;
      fin_d = 1'b1;
    end else if (at_end_i) begin
      g.kind[0] = jst_pkg::TK_FINISH; emit = 1'b1; fin_d = 1'b1;
      g.status = ((phase_q == PH_AFTER || phase_q == PH_ZERO || phase_q == PH_INT ||
                   phase_q == PH_FRAC || phase_q == PH_EXP_DIG) && lvl_q == '0)
                 ? jst_pkg::ST_OK : jst_pkg::ST_EARLY;
    end else begin
      case (phase_q)
        PH_VALUE, PH_ARR_FIRST: begin
          if (phase_q == PH_ARR_FIRST && c == 21'h5D) cls = 1'b1;
          else if (is_ws(c)) begin end
          else if (c >= 21'h31 && c <= 21'h39) begin
            phase_d = PH_INT; emit = 1'b1; g.byte_v[0] = c[7:0];
          end else begin
            case (c)
              21'h30: begin phase_d = PH_ZERO; emit = 1'b1; g.byte_v[0] = c[7:0]; end
              21'h2D: begin phase_d = PH_MINUS; emit = 1'b1; g.byte_v[0] = c[7:0]; end
              21'h66: begin phase_d = PH_FALSE; sub_d = '0; emit = 1'b1;
                g.kind[0] = jst_pkg::TK_FALSE; end
              21'h6E: begin phase_d = PH_NULL; sub_d = '0; emit = 1'b1;
                g.kind[0] = jst_pkg::TK_NULL; end
              21'h74: begin phase_d = PH_TRUE; sub_d = '0; emit = 1'b1;
                g.kind[0] = jst_pkg::TK_TRUE; end
              21'h22: begin phase_d = PH_STR; emit = 1'b1; g.kind[0] = jst_pkg::TK_STR_B; end
              21'h5B: opn = 1'b1;
              21'h7B: begin opn = 1'b1; opn_obj = 1'b1; end
              default: begin emit = 1'b1; fin_d = 1'b1; g.kind[0] = jst_pkg::TK_FINISH;
                g.status = jst_pkg::ST_SYNTAX; end
            endcase
          end
        end
        PH_OBJ_FIRST, PH_OBJ_KEY: begin
          if (is_ws(c)) begin end
          else if (c == 21'h22) begin
            phase_d = PH_KEY; emit = 1'b1; g.kind[0] = jst_pkg::TK_STR_B;
          end else if (phase_q == PH_OBJ_FIRST && c == 21'h7D) cls = 1'b1;
          else begin emit = 1'b1; fin_d = 1'b1; g.kind[0] = jst_pkg::TK_FINISH;
            g.status = jst_pkg::ST_SYNTAX; end
        end
        PH_COLON: begin
          if (is_ws(c)) begin end
          else if (c == 21'h3A) begin
            phase_d = PH_VALUE; emit = 1'b1; g.kind[0] = jst_pkg::TK_COLON;
          end else begin emit = 1'b1; fin_d = 1'b1; g.kind[0] = jst_pkg::TK_FINISH;
            g.status = jst_pkg::ST_SYNTAX; end
        end
        PH_STR, PH_KEY: begin
          str_key = (phase_q == PH_KEY);
          if (c == 21'h22) begin
            phase_d = str_key ? PH_COLON : PH_AFTER; emit = 1'b1;
            g.kind[0] = jst_pkg::TK_STR_E;
          end else if (c == 21'h5C) phase_d = phase_q + 5'd1;
          else if (c < 21'h20) begin emit = 1'b1; fin_d = 1'b1;
            g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_SYNTAX; end
          else begin
            emit = 1'b1;
            if (c < 21'h80) g.byte_v[0] = c[7:0];
            else if (c < 21'h800) begin
              g.cnt = 3'd2; g.byte_v[0] = {3'b110, c[10:6]}; g.byte_v[1] = {2'b10, c[5:0]};
            end else if (c < 21'h10000) begin
              g.cnt = 3'd3; g.byte_v[0] = {4'b1110, c[15:12]};
              g.byte_v[1] = {2'b10, c[11:6]}; g.byte_v[2] = {2'b10, c[5:0]};
            end else begin
              g.cnt = 3'd4; g.byte_v[0] = {5'b11110, c[20:18]};
              g.byte_v[1] = {2'b10, c[17:12]}; g.byte_v[2] = {2'b10, c[11:6]};
              g.byte_v[3] = {2'b10, c[5:0]};
            end
          end
        end
        PH_STR_ESC, PH_KEY_ESC: begin
          emit = 1'b1; phase_d = phase_q - 5'd1;
          case (c)
            21'h22, 21'h5C, 21'h2F: g.byte_v[0] = c[7:0];
            21'h62: g.byte_v[0] = 8'h08;
            21'h66: g.byte_v[0] = 8'h0C;
            21'h6E: g.byte_v[0] = 8'h0A;
            21'h72: g.byte_v[0] = 8'h0D;
            21'h74: g.byte_v[0] = 8'h09;
            21'h75: begin emit = 1'b0; phase_d = phase_q + 5'd1; sub_d = '0; end
            default: begin phase_d = phase_q; fin_d = 1'b1;
              g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_SYNTAX; end
          endcase
        end
        PH_STR_HEX, PH_KEY_HEX: begin
          if (!is_hex(c)) begin emit = 1'b1; fin_d = 1'b1;
            g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_SYNTAX; end
          else if (sub_q >= 3'd3) begin sub_d = '0; phase_d = phase_q - 5'd2; end
          else sub_d = sub_q + 3'd1;
        end
        PH_FALSE, PH_NULL, PH_TRUE: begin
          w  = 2'(phase_q - PH_FALSE);
          ni = {1'b0, sub_q[1:0]} + 3'd1;
          if (c != {13'd0, lit_char(w, sub_q[1:0])}) begin emit = 1'b1; fin_d = 1'b1;
            g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_SYNTAX; end
          else if (ni >= ((w == 2'd0) ? 3'd4 : 3'd3)) begin sub_d = '0; phase_d = PH_AFTER; end
          else sub_d = ni;
        end
        PH_MINUS, PH_DOT, PH_EXP_SIGN: begin
          if (is_dig(c)) begin
            emit = 1'b1; g.byte_v[0] = c[7:0];
            phase_d = (phase_q == PH_DOT) ? PH_FRAC : (phase_q == PH_EXP_SIGN) ? PH_EXP_DIG
                    : (c == 21'h30) ? PH_ZERO : PH_INT;
          end else begin emit = 1'b1; fin_d = 1'b1; g.kind[0] = jst_pkg::TK_FINISH;
            g.status = jst_pkg::ST_SYNTAX; end
        end
        PH_EXP: begin
          if (c == 21'h2B) phase_d = PH_EXP_SIGN;
          else if (c == 21'h2D || is_dig(c)) begin
            phase_d = (c == 21'h2D) ? PH_EXP_SIGN : PH_EXP_DIG; emit = 1'b1;
            g.byte_v[0] = c[7:0];
          end else begin emit = 1'b1; fin_d = 1'b1; g.kind[0] = jst_pkg::TK_FINISH;
            g.status = jst_pkg::ST_SYNTAX; end
        end
        PH_INT, PH_ZERO, PH_FRAC, PH_EXP_DIG: begin
          if (is_dig(c) && phase_q != PH_ZERO) begin emit = 1'b1; g.byte_v[0] = c[7:0]; end
          else if (c == 21'h2E && (phase_q == PH_INT || phase_q == PH_ZERO)) begin
            phase_d = PH_DOT; emit = 1'b1; g.byte_v[0] = c[7:0];
          end else if ((c == 21'h65 || c == 21'h45) && phase_q != PH_EXP_DIG) begin
            phase_d = PH_EXP; emit = 1'b1; g.kind[0] = jst_pkg::TK_EXP;
          end else aft = 1'b1;
        end
        default: aft = 1'b1;
      endcase
      // after a value: comma, close or trailing text
      if (aft) begin
        phase_d = PH_AFTER;
        if (is_ws(c)) begin end
        else if (lvl_q == '0) begin emit = 1'b1; fin_d = 1'b1;
          g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_SYNTAX; end
        else if (c == 21'h2C) begin
          phase_d = top_q ? PH_OBJ_KEY : PH_VALUE; emit = 1'b1;
          g.kind[0] = jst_pkg::TK_COMMA;
        end else if (c == (top_q ? 21'h7D : 21'h5D)) cls = 1'b1;
        else begin emit = 1'b1; fin_d = 1'b1; g.kind[0] = jst_pkg::TK_FINISH;
          g.status = jst_pkg::ST_SYNTAX; end
      end
      if (cls) begin
        pop = 1'b1; lvl_d = lvl_q - LW'(1); phase_d = PH_AFTER; emit = 1'b1;
        g.kind[0] = top_q ? jst_pkg::TK_OBJ_E : jst_pkg::TK_ARR_E;
        top_d = (lvl_q > LW'(1)) ? below_q : 1'b0;
      end
      if (opn) begin
        emit = 1'b1;
        if (lvl_q >= LW'(NEST_DEPTH)) begin fin_d = 1'b1;
          g.kind[0] = jst_pkg::TK_FINISH; g.status = jst_pkg::ST_OVERFLOW; end
        else begin
          push = 1'b1; push_kind = opn_obj; lvl_d = lvl_q + LW'(1); top_d = opn_obj;
          phase_d = opn_obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
          g.kind[0] = opn_obj ? jst_pkg::TK_OBJ_B : jst_pkg::TK_ARR_B;
        end
      end
    end
    if (fin_q) begin
      emit = 1'b0; fin_d = fin_q; phase_d = phase_q; lvl_d = lvl_q; sub_d = sub_q;
      top_d = top_q; push = 1'b0; pop = 1'b0;
    end
    grp_valid_o = in_valid_i && emit;
  end
  assign grp_o = g;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VALUE; lvl_q <= '0; sub_q <= '0; fin_q <= 1'b0; top_q <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d; lvl_q <= lvl_d; sub_q <= sub_d; fin_q <= fin_d; top_q <= top_d;
    end
  end

  // nesting stack, one bit per level; the entry under the next top is read
  // into a register so a pop finds it ready
  always_ff @(posedge clk_i) begin
    if (acc && push) kinds_q[AW'(lvl_q)] <= push_kind;
    below_q <= kinds_q[AW'(rd_lvl - LW'(2))];
  end

  `JST_ASSERT_NEXT(a_fin_sticky, clk_i, rst_ni, fin_q, fin_q)
  `JST_ASSERT_IMPL(a_lvl_range, clk_i, rst_ni, 1'b1, lvl_q <= LW'(NEST_DEPTH))
  `JST_ASSERT_IMPL(a_no_out_after_fin, clk_i, rst_ni, fin_q, !grp_valid_o)
  `JST_ASSERT_IMPL(a_push_pop, clk_i, rst_ni, acc, !(push && pop))
endmodule

// ----- rtl/jst_back.sv -----
// ----------------------------------------------------------------------------
// jst_back
// Two-entry group queue and serializer: hands out one token per cycle while the output does not stall.
// ----------------------------------------------------------------------------
`include "json_stream_tokenizer_top_macros.svh"
module jst_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              grp_valid_i,
  output logic              grp_full_o,
  input  jst_pkg::tok_grp_t grp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        token_kind_o,
  output logic [7:0]        byte_value_o,
  output logic [2:0]        status_o,
  output logic              last_o
);
  jst_pkg::tok_grp_t mem_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic [1:0] idx_q;
  logic       pop, push;
  jst_pkg::tok_grp_t h;
  logic       fin;

  assign h           = mem_q[rd_q];
  assign out_valid_o = cnt_q != 2'd0;
  assign grp_full_o  = cnt_q == 2'd2;
  assign push        = grp_valid_i && !grp_full_o;
  assign fin         = h.kind[idx_q] == jst_pkg::TK_FINISH;
  assign token_kind_o = h.kind[idx_q];
  assign byte_value_o = (h.kind[idx_q] == jst_pkg::TK_BYTE) ? h.byte_v[idx_q] : 8'd0;
  assign status_o     = fin ? h.status : jst_pkg::ST_OK;
  assign last_o       = ({1'b0, idx_q} + 3'd1) == h.cnt;
  assign pop          = out_valid_o && !out_stall_i && last_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= grp_i;
  end

  // pointers and token index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; idx_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) begin rd_q <= ~rd_q; idx_q <= '0; end
      else if (out_valid_o && !out_stall_i) idx_q <= idx_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `JST_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2)
  `JST_ASSERT_IMPL(a_idx_bound, clk_i, rst_ni, out_valid_o, ({1'b0, idx_q}) < h.cnt)
  `JST_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(token_kind_o))
endmodule
